/* rtl/gbsf_pkg.sv */
package gbsf_pkg;

   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = IDX_BITS + 1;
   localparam int SCAN_BITS     = 20;
   localparam int KEY_BITS      = SCAN_BITS + 4;
   localparam int VAL_BITS      = 32;
   localparam int PROD_BITS     = 2 * VAL_BITS;
   localparam int ACC_BITS      = PROD_BITS + 4;
   localparam int FRAC_BITS     = 16;
   localparam int ENTRY_BITS    = KEY_BITS + 2 * VAL_BITS;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_RT    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_RANK  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_FRAG  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COEFF_COEL  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILTER_EN   = 3'd4;

   typedef enum logic [1:0] {
      OP_BUILD  = 2'd0,
      OP_FILTER = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_UNUSED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_ACC,
      S_SAT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic       acc;
      logic [1:0] term;
      logic       sat;
      logic       rd;
      logic       cmp;
      logic       next;
      logic       finish;
      logic       busy;
   } cmd_type;

   typedef struct packed {
      logic scan_end;
      logic key_match;
      logic out_free;
   } stat_type;

endpackage

/* rtl/grouped_best_score_filter_core.sv */
// Grouped best-score filter.
// Input channel req_*: one row item per handshake (req_valid high, req_stall low).
// Opcode build keeps, per (scan, charge) key, the row with the highest xcorr and
// its ensemble score; filter compares a row against that baseline; clear
// empties the table. Every item gives exactly one result item on rsp_*.
// Configuration csr_*: write coefficients and filter enable while idle.
// Build and filter run the multiply steps for each term, then search the table
// from entry 0 until the key is found or all stored entries are read; clear and
// the unused opcode go straight to the result. The next item can be accepted
// in the cycle after the result is loaded.
// The rate is set by the linear key search, one table entry at a time
// through the single read port, and the shared multiplier, one term at a
// time. One item is in work at a time; req_stall is high while busy.
// The result sits in an output register, so a new item is accepted while
// the receiver stalls; that item then holds in its last step until the
// register frees. Reset restores the coefficients to 1.0, filtering on,
// and empties the table at once (fill count cleared, no sweep).
module grouped_best_score_filter_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [19:0]         req_scan_number,
   input  logic [3:0]          req_charge_state,
   input  logic signed [31:0]  req_xcorr_value,
   input  logic signed [31:0]  req_tailor_value,
   input  logic signed [31:0]  req_rt_difference_value,
   input  logic signed [31:0]  req_precursor_rank_value,
   input  logic signed [31:0]  req_fragment_pvalue_value,
   input  logic signed [31:0]  req_coelution_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_ensemble_score,
   output logic                rsp_keep_row,
   output logic [1:0]          rsp_status_code,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   gbsf_pkg::cmd_type  cmd;
   gbsf_pkg::stat_type stat;

   // sequencer: multiply steps, table search, result handoff
   gbsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .stat       (stat),
      .cmd        (cmd)
   );

   // arithmetic, entry table, registers and the result register
   gbsf_datapath u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .req_opcode                (req_opcode),
      .req_scan_number           (req_scan_number),
      .req_charge_state          (req_charge_state),
      .req_xcorr_value           (req_xcorr_value),
      .req_tailor_value          (req_tailor_value),
      .req_rt_difference_value   (req_rt_difference_value),
      .req_precursor_rank_value  (req_precursor_rank_value),
      .req_fragment_pvalue_value (req_fragment_pvalue_value),
      .req_coelution_value       (req_coelution_value),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_ensemble_score        (rsp_ensemble_score),
      .rsp_keep_row              (rsp_keep_row),
      .rsp_status_code           (rsp_status_code),
      .csr_write_enable          (csr_write_enable),
      .csr_index                 (csr_index),
      .csr_data                  (csr_data)
   );

   // hold off new items while one is in work
   assign req_stall = cmd.busy;

   // an accepted item makes the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted item did not make the block busy");

   // a full table never reports a kept row
   a_full_no_keep: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_code == gbsf_pkg::STATUS_FULL) |-> !rsp_keep_row)
      else $error("table-full result marked as kept");

   // the unused status code never reaches the result channel
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status_code != gbsf_pkg::STATUS_UNUSED))
      else $error("unused status code on result");

   // a result is loaded only while the block finishes an item
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> $past(req_stall))
      else $error("result appeared without an item in work");

endmodule

/* rtl/gbsf_ctrl.sv */
module gbsf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   input  gbsf_pkg::stat_type  stat,
   output gbsf_pkg::cmd_type   cmd
);

   gbsf_pkg::state_type state_ff, state_in;
   logic [1:0]          term_ff, term_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbsf_pkg::S_IDLE;
         term_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      unique case (state_ff)
         gbsf_pkg::S_IDLE: begin
            term_in = 2'd0;
            if (req_valid) begin
               if (req_opcode == gbsf_pkg::OP_BUILD || req_opcode == gbsf_pkg::OP_FILTER)
                  state_in = gbsf_pkg::S_MUL;
               else
                  state_in = gbsf_pkg::S_DONE;
            end
         end
         gbsf_pkg::S_MUL: state_in = gbsf_pkg::S_ACC;
         gbsf_pkg::S_ACC: begin
            term_in  = term_ff + 2'd1;
            state_in = (term_ff == 2'd3) ? gbsf_pkg::S_SAT : gbsf_pkg::S_MUL;
         end
         gbsf_pkg::S_SAT: state_in = gbsf_pkg::S_SCAN_RD;
         gbsf_pkg::S_SCAN_RD:
            state_in = stat.scan_end ? gbsf_pkg::S_DONE : gbsf_pkg::S_SCAN_CMP;
         gbsf_pkg::S_SCAN_CMP:
            state_in = stat.key_match ? gbsf_pkg::S_DONE : gbsf_pkg::S_SCAN_RD;
         gbsf_pkg::S_DONE:
            if (stat.out_free) state_in = gbsf_pkg::S_IDLE;
         default: state_in = gbsf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.term   = term_ff;
      cmd.busy   = (state_ff != gbsf_pkg::S_IDLE);
      unique case (state_ff)
         gbsf_pkg::S_IDLE:     cmd.load   = req_valid;
         gbsf_pkg::S_MUL:      cmd.mul    = 1'b1;
         gbsf_pkg::S_ACC:      cmd.acc    = 1'b1;
         gbsf_pkg::S_SAT:      cmd.sat    = 1'b1;
         gbsf_pkg::S_SCAN_RD:  cmd.rd     = !stat.scan_end;
         gbsf_pkg::S_SCAN_CMP: begin
            cmd.cmp  = 1'b1;
            cmd.next = !stat.key_match;
         end
         gbsf_pkg::S_DONE:     cmd.finish = stat.out_free;
         default: ;
      endcase
   end

endmodule

/* rtl/gbsf_datapath.sv */
module gbsf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  gbsf_pkg::cmd_type   cmd,
   output gbsf_pkg::stat_type  stat,
   input  logic [1:0]          req_opcode,
   input  logic [19:0]         req_scan_number,
   input  logic [3:0]          req_charge_state,
   input  logic signed [31:0]  req_xcorr_value,
   input  logic signed [31:0]  req_tailor_value,
   input  logic signed [31:0]  req_rt_difference_value,
   input  logic signed [31:0]  req_precursor_rank_value,
   input  logic signed [31:0]  req_fragment_pvalue_value,
   input  logic signed [31:0]  req_coelution_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_ensemble_score,
   output logic                rsp_keep_row,
   output logic [1:0]          rsp_status_code,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   localparam int VB = gbsf_pkg::VAL_BITS;
   localparam int KB = gbsf_pkg::KEY_BITS;
   localparam int AB = gbsf_pkg::ACC_BITS;
   localparam int SB = AB - gbsf_pkg::FRAC_BITS;

   logic signed [VB-1:0] coeff_rt_ff, coeff_rank_ff, coeff_frag_ff, coeff_coel_ff;
   logic                 filter_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_rt_ff   <= 32'sd65536;
         coeff_rank_ff <= 32'sd65536;
         coeff_frag_ff <= 32'sd65536;
         coeff_coel_ff <= 32'sd65536;
         filter_en_ff  <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            gbsf_pkg::CSR_COEFF_RT:   coeff_rt_ff   <= csr_data;
            gbsf_pkg::CSR_COEFF_RANK: coeff_rank_ff <= csr_data;
            gbsf_pkg::CSR_COEFF_FRAG: coeff_frag_ff <= csr_data;
            gbsf_pkg::CSR_COEFF_COEL: coeff_coel_ff <= csr_data;
            gbsf_pkg::CSR_FILTER_EN:  filter_en_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // latched item
   gbsf_pkg::opcode_type op_ff;
   logic [KB-1:0]        key_ff;
   logic signed [VB-1:0] xcorr_ff, rt_ff, rank_ff, frag_ff, coel_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= gbsf_pkg::opcode_type'(req_opcode);
         key_ff   <= {req_scan_number[gbsf_pkg::SCAN_BITS-1:0], req_charge_state};
         xcorr_ff <= req_xcorr_value;
         rt_ff    <= req_rt_difference_value;
         rank_ff  <= req_precursor_rank_value;
         frag_ff  <= req_fragment_pvalue_value;
         coel_ff  <= req_coelution_value;
      end
   end

   // shared multiplier, then accumulate exact Q36.32 sum
   logic signed [VB-1:0]                 mul_a, mul_b;
   logic signed [gbsf_pkg::PROD_BITS-1:0] prod_ff;
   logic                                  neg_ff;
   logic signed [AB-1:0]                  acc_ff;
   logic signed [SB-1:0]                  shifted;
   logic signed [VB-1:0]                  ens_ff, ens_sat;

   always_comb begin
      case (cmd.term)
         2'd0:    begin mul_a = coeff_rt_ff;   mul_b = rt_ff;   end
         2'd1:    begin mul_a = coeff_rank_ff; mul_b = rank_ff; end
         2'd2:    begin mul_a = coeff_frag_ff; mul_b = frag_ff; end
         default: begin mul_a = coeff_coel_ff; mul_b = coel_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= mul_a * mul_b;
         neg_ff  <= (cmd.term == 2'd0) || (cmd.term == 2'd1);
      end
      if (cmd.load)
         acc_ff <= AB'(req_tailor_value) <<< gbsf_pkg::FRAC_BITS;
      else if (cmd.acc)
         acc_ff <= neg_ff ? acc_ff - AB'(prod_ff) : acc_ff + AB'(prod_ff);
      if (cmd.sat)
         ens_ff <= ens_sat;
   end

   // floor to Q16.16, then saturate
   always_comb begin
      shifted = SB'(acc_ff >>> gbsf_pkg::FRAC_BITS);
      if (shifted > SB'(32'sh7FFFFFFF))
         ens_sat = 32'sh7FFFFFFF;
      else if (shifted < -SB'(64'sh80000000))
         ens_sat = 32'sh80000000;
      else
         ens_sat = VB'(shifted);
   end

   // entry table, filled in order
   logic [gbsf_pkg::ENTRY_BITS-1:0] mem [gbsf_pkg::TABLE_ENTRIES];
   logic [gbsf_pkg::ENTRY_BITS-1:0] mem_q;
   logic [gbsf_pkg::CNT_BITS-1:0]   count_ff, idx_ff;
   logic                            found_ff;
   logic                            wr_en;
   logic [gbsf_pkg::IDX_BITS-1:0]   wr_addr;
   logic [KB-1:0]                   q_key;
   logic signed [VB-1:0]            q_xcorr, q_base;

   assign q_key   = mem_q[gbsf_pkg::ENTRY_BITS-1 -: KB];
   assign q_xcorr = mem_q[2*VB-1 -: VB];
   assign q_base  = mem_q[VB-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd)
         mem_q <= mem[idx_ff[gbsf_pkg::IDX_BITS-1:0]];
      if (wr_en)
         mem[wr_addr] <= {key_ff, xcorr_ff, ens_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.sat) begin
         idx_ff   <= '0;
      end else if (cmd.next) begin
         idx_ff   <= idx_ff + gbsf_pkg::CNT_BITS'(1);
      end
      if (cmd.load)
         found_ff <= 1'b0;
      else if (cmd.cmp && stat.key_match)
         found_ff <= 1'b1;
   end

   assign stat.scan_end  = (idx_ff == count_ff);
   assign stat.key_match = (q_key == key_ff);
   assign stat.out_free  = !rsp_valid || !rsp_stall;

   // resolve the item and update the table
   logic                 table_full;
   logic signed [VB-1:0] res_ens;
   logic                 res_keep;
   gbsf_pkg::status_type res_status;

   assign table_full = (count_ff == gbsf_pkg::CNT_BITS'(gbsf_pkg::TABLE_ENTRIES));

   always_comb begin
      res_ens    = '0;
      res_keep   = 1'b0;
      res_status = gbsf_pkg::STATUS_OK;
      wr_en      = 1'b0;
      wr_addr    = count_ff[gbsf_pkg::IDX_BITS-1:0];
      case (op_ff)
         gbsf_pkg::OP_BUILD: begin
            res_ens = ens_ff;
            if (found_ff) begin
               wr_addr = idx_ff[gbsf_pkg::IDX_BITS-1:0];
               wr_en   = cmd.finish && (q_xcorr < xcorr_ff);
            end else if (!table_full) begin
               wr_en = cmd.finish;
            end else begin
               res_status = gbsf_pkg::STATUS_FULL;
            end
         end
         gbsf_pkg::OP_FILTER: begin
            res_ens = ens_ff;
            if (found_ff) begin
               res_keep = !filter_en_ff || (ens_ff >= q_base);
            end else begin
               res_status = gbsf_pkg::STATUS_ABSENT;
               res_keep   = !filter_en_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         if (op_ff == gbsf_pkg::OP_CLEAR)
            count_ff <= '0;
         else if (op_ff == gbsf_pkg::OP_BUILD && !found_ff && !table_full)
            count_ff <= count_ff + gbsf_pkg::CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid <= 1'b0;
      else if (cmd.finish)
         rsp_valid <= 1'b1;
      else if (!rsp_stall)
         rsp_valid <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ensemble_score <= res_ens;
         rsp_keep_row       <= res_keep;
         rsp_status_code    <= res_status;
      end
   end

endmodule
